/* src/srct_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the station retry counter table.
// Used by every module of the block; depends on nothing.
package srct_pkg;

  // Event codes carried on the mode field. Code 7 is unused and acts as a query.
  localparam logic [2:0] MODE_QUERY       = 3'd0;
  localparam logic [2:0] MODE_RTS_FAIL    = 3'd1;
  localparam logic [2:0] MODE_DATA_FAIL   = 3'd2;
  localparam logic [2:0] MODE_RTS_OK      = 3'd3;
  localparam logic [2:0] MODE_DATA_OK     = 3'd4;
  localparam logic [2:0] MODE_FINAL_RTS   = 3'd5;
  localparam logic [2:0] MODE_FINAL_DATA  = 3'd6;

  // Configuration register indexes.
  localparam logic REG_SHORT_LIMIT = 1'b0;
  localparam logic REG_LONG_LIMIT  = 1'b1;

  // Reset value of both retry limits.
  localparam logic [7:0] RESET_RETRY_LIMIT = 8'd7;

  // Largest value of a retry counter.
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [47:0] address;
    logic [3:0]  traffic_id;
    logic [7:0]  short_count;
    logic [7:0]  long_count;
  } srct_entry_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] short_retry_count;
    logic [7:0] long_retry_count;
    logic [7:0] cleared_count;
    logic       rts_retry_allowed;
    logic       data_retry_allowed;
    logic       entry_created;
    logic       table_full;
  } srct_result_t;

endpackage

/* src/srct_store.sv */
`timescale 1ns / 1ps
// Entry memory of the station table: one write port, one read port, registered read.
// Depends on srct_pkg for the entry type.
module srct_store #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  output srct_pkg::srct_entry_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  srct_pkg::srct_entry_t wr_data_i
);
  import srct_pkg::*;

  srct_entry_t mem_q [Depth];
  srct_entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/srct_outreg.sv */
`timescale 1ns / 1ps
// Output holding register for result beats, with valid and stall toward the sink.
// Depends on srct_pkg for the result type.
module srct_outreg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  srct_pkg::srct_result_t push_data_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output srct_pkg::srct_result_t out_data_o
);
  import srct_pkg::*;

  logic         valid_q;
  srct_result_t data_q;

  // The register can take a new beat when empty or when its beat leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

`ifndef ASSERT_OFF
  // A beat is only loaded when the register has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> ready_o)
    else $error("outreg: push while full");
  // A loaded beat is visible in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |=> out_valid_o)
    else $error("outreg: pushed beat not shown");
  // A beat that is still waiting keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> $stable(data_q))
    else $error("outreg: waiting beat changed");
`endif

endmodule

/* src/srct_ctrl.sv */
`timescale 1ns / 1ps
// Lookup sequencer: scans valid entries through the memory read port, creates missing
// entries if there is room, updates the counters, writes them back. Depends on srct_pkg.
module srct_ctrl #(
  parameter int Depth = 16,
  parameter int IdxW  = 4,
  parameter int CntW  = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             mode_i,
  input  logic [47:0]            station_address_i,
  input  logic [3:0]             traffic_id_i,
  // Retry limits
  input  logic [7:0]             short_limit_i,
  input  logic [7:0]             long_limit_i,
  // Memory ports
  output logic                   rd_en_o,
  output logic [IdxW-1:0]        rd_idx_o,
  input  srct_pkg::srct_entry_t  rd_data_i,
  output logic                   wr_en_o,
  output logic [IdxW-1:0]        wr_idx_o,
  output srct_pkg::srct_entry_t  wr_data_o,
  // Result toward the output register
  output logic                   push_o,
  output srct_pkg::srct_result_t push_data_o,
  input  logic                   push_ready_i
);
  import srct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD
  } state_e;

  localparam logic [CntW-1:0] FullCount = CntW'(Depth);

  state_e          state_q;
  logic [CntW-1:0] fill_q;
  logic [2:0]      mode_q;
  logic [47:0]     addr_q;
  logic [3:0]      tid_q;
  logic            issue_q;
  logic            pend_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] pend_idx_q;
  logic [IdxW-1:0] slot_q;
  srct_entry_t     ent_q;
  logic            created_q;
  logic            full_q;

  logic            in_accept;
  logic            hit;
  logic            last_issue;
  logic            miss;
  logic [7:0]      new_short;
  logic [7:0]      new_long;
  logic [7:0]      cleared;
  srct_entry_t     upd_entry;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Key compare on the entry read in the previous cycle.
  assign hit = pend_q && (rd_data_i.address == addr_q) && (rd_data_i.traffic_id == tid_q);
  assign last_issue = (CntW'(rd_idx_q) == (fill_q - 1'b1));
  assign miss = !issue_q && !hit;

  // Read one entry per cycle while the scan runs.
  assign rd_en_o  = (state_q == S_SCAN) && issue_q;
  assign rd_idx_o = rd_idx_q;

  // Counter update for the event.
  always_comb begin
    new_short = ent_q.short_count;
    new_long  = ent_q.long_count;
    cleared   = 8'd0;
    unique case (mode_q)
      MODE_RTS_FAIL: begin
        if (ent_q.short_count != COUNT_MAX) new_short = ent_q.short_count + 8'd1;
      end
      MODE_DATA_FAIL: begin
        if (ent_q.long_count != COUNT_MAX) new_long = ent_q.long_count + 8'd1;
      end
      MODE_RTS_OK: begin
        cleared   = ent_q.short_count;
        new_short = 8'd0;
      end
      MODE_DATA_OK: begin
        cleared  = ent_q.long_count;
        new_long = 8'd0;
      end
      MODE_FINAL_RTS:  new_short = 8'd0;
      MODE_FINAL_DATA: new_long  = 8'd0;
      default: ;
    endcase
  end

  always_comb begin
    upd_entry             = ent_q;
    upd_entry.short_count = new_short;
    upd_entry.long_count  = new_long;
  end

  // Write back and hand over the result once the output register has room.
  assign push_o    = (state_q == S_UPD) && push_ready_i;
  assign wr_en_o   = push_o && !full_q;
  assign wr_idx_o  = slot_q;
  assign wr_data_o = upd_entry;

  always_comb begin
    if (full_q) begin
      push_data_o            = '0;
      push_data_o.table_full = 1'b1;
    end else begin
      push_data_o.short_retry_count  = new_short;
      push_data_o.long_retry_count   = new_long;
      push_data_o.cleared_count      = cleared;
      push_data_o.rts_retry_allowed  = (new_short < short_limit_i);
      push_data_o.data_retry_allowed = (new_long < long_limit_i);
      push_data_o.entry_created      = created_q;
      push_data_o.table_full         = 1'b0;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_SCAN;
            issue_q <= (fill_q != '0);
            pend_q  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (hit || miss) begin
            state_q <= S_UPD;
            issue_q <= 1'b0;
            pend_q  <= 1'b0;
            if (!hit && (fill_q != FullCount)) begin
              fill_q <= fill_q + 1'b1;
            end
          end else begin
            pend_q <= issue_q;
            if (issue_q && last_issue) begin
              issue_q <= 1'b0;
            end
          end
        end
        S_UPD: begin
          if (push_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item and scan payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= mode_i;
      addr_q   <= station_address_i;
      tid_q    <= traffic_id_i;
      rd_idx_q <= '0;
    end
    if (state_q == S_SCAN) begin
      pend_idx_q <= rd_idx_q;
      if (issue_q && !last_issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (hit) begin
        slot_q    <= pend_idx_q;
        ent_q     <= rd_data_i;
        created_q <= 1'b0;
        full_q    <= 1'b0;
      end else if (miss) begin
        slot_q                 <= IdxW'(fill_q);
        ent_q.address          <= addr_q;
        ent_q.traffic_id       <= tid_q;
        ent_q.short_count      <= 8'd0;
        ent_q.long_count       <= 8'd0;
        created_q              <= (fill_q != FullCount);
        full_q                 <= (fill_q == FullCount);
      end
    end
  end

`ifndef ASSERT_OFF
  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FullCount)
    else $error("ctrl: fill count overflow");
  // Only entries that were written are ever read.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en_o |-> (CntW'(rd_idx_q) < fill_q))
    else $error("ctrl: read of an unfilled entry");
  // The memory is written only at the end of an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_o |-> (state_q == S_UPD))
    else $error("ctrl: write outside update");
  // An accepted beat always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> (state_q == S_SCAN))
    else $error("ctrl: accepted beat did not start a scan");
  // A table full result never comes with a created entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !(push_data_o.table_full && push_data_o.entry_created))
    else $error("ctrl: full and created together");
`endif

endmodule

/* src/station_retry_counter_table_core.sv */
`timescale 1ns / 1ps
// Station retry counter table, top level. A beat that hits entry k shows its result once
// the scan has read entry k; a miss shows it once all filled entries are read, as the
// scan reads one entry per cycle. A new beat is taken the cycle after the result enters
// the output register, so a beat is not taken while an earlier one is still in work.
// Reset empties the table (fill count zero, no memory clearing) and sets both retry
// limits to 7.
module station_retry_counter_table_core #(
  parameter int STATION_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [47:0] station_address_i,
  input  logic [3:0]  traffic_id_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  short_retry_count_o,
  output logic [7:0]  long_retry_count_o,
  output logic [7:0]  cleared_count_o,
  output logic        rts_retry_allowed_o,
  output logic        data_retry_allowed_o,
  output logic        entry_created_o,
  output logic        table_full_o
);
  import srct_pkg::*;

  localparam int IdxW = (STATION_ENTRIES > 1) ? $clog2(STATION_ENTRIES) : 1;
  localparam int CntW = $clog2(STATION_ENTRIES + 1);

  logic [7:0]      short_limit_q;
  logic [7:0]      long_limit_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_idx;
  srct_entry_t     rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  srct_entry_t     wr_data;
  logic            push;
  logic            push_ready;
  srct_result_t    push_data;
  srct_result_t    out_data;

  // Retry limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_limit_q <= RESET_RETRY_LIMIT;
      long_limit_q  <= RESET_RETRY_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SHORT_LIMIT: short_limit_q <= cfg_wdata_i;
        REG_LONG_LIMIT:  long_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  srct_store #(
    .Depth (STATION_ENTRIES),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  srct_ctrl #(
    .Depth (STATION_ENTRIES),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .station_address_i (station_address_i),
    .traffic_id_i      (traffic_id_i),
    .short_limit_i     (short_limit_q),
    .long_limit_i      (long_limit_q),
    .rd_en_o           (rd_en),
    .rd_idx_o          (rd_idx),
    .rd_data_i         (rd_data),
    .wr_en_o           (wr_en),
    .wr_idx_o          (wr_idx),
    .wr_data_o         (wr_data),
    .push_o            (push),
    .push_data_o       (push_data),
    .push_ready_i      (push_ready)
  );

  srct_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (push_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign short_retry_count_o  = out_data.short_retry_count;
  assign long_retry_count_o   = out_data.long_retry_count;
  assign cleared_count_o      = out_data.cleared_count;
  assign rts_retry_allowed_o  = out_data.rts_retry_allowed;
  assign data_retry_allowed_o = out_data.data_retry_allowed;
  assign entry_created_o      = out_data.entry_created;
  assign table_full_o         = out_data.table_full;

endmodule
